FILE: rtl/bre_pkg.sv
package bre_pkg;

    // Field widths fixed by the reading and estimate formats.
    localparam int CHARGE_W  = 24;
    localparam int CURRENT_W = 24;
    localparam int STATUS_W  = 2;
    localparam int HOURS_W   = 24;
    localparam int MINUTES_W = 6;
    localparam int PERCENT_W = 7;
    localparam int LEVEL_W   = 4;

    // Defaults for the top-level parameters.
    localparam int WINDOW_DEPTH_DEF = 10;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int MINUTES_PER_HOUR = 60;
    localparam int PERCENT_FULL     = 100;
    localparam int PERCENT_ROUND_UP = 99;

    // Charge status codes as they arrive on the reading channel.
    localparam logic [STATUS_W-1:0] CODE_CHARGING    = 2'd0;
    localparam logic [STATUS_W-1:0] CODE_DISCHARGING = 2'd1;
    localparam logic [STATUS_W-1:0] CODE_FULL        = 2'd2;

    // Status as remembered between readings; NONE means nothing seen yet.
    typedef enum logic [1:0] {
        ST_NONE        = 2'd0,
        ST_CHARGING    = 2'd1,
        ST_DISCHARGING = 2'd2,
        ST_FULL        = 2'd3
    } status_t;

    typedef struct packed {
        logic [CHARGE_W-1:0]  full_charge;
        logic [CHARGE_W-1:0]  present_charge;
        logic [CURRENT_W-1:0] present_current;
        logic [STATUS_W-1:0]  charge_status;
    } reading_t;

    typedef struct packed {
        logic                 is_full;
        logic                 time_unknown;
        logic [HOURS_W-1:0]   hours_left;
        logic [MINUTES_W-1:0] minutes_left;
        logic [PERCENT_W-1:0] percent_charged;
        logic [LEVEL_W-1:0]   level_index;
        logic                 refresh;
    } estimate_t;

    // Commands to the sample window.
    typedef struct packed {
        logic clear;
        logic write;
        logic scan;
    } win_cmd_t;

    // Status reported by the window scanner and the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

FILE: rtl/battery_runtime_estimator.sv
// Battery runtime estimator.
// A reading (full charge, present charge, present current, charge status) is taken
// on the reading channel when reading_valid and reading_ready are both high; each
// reading gives exactly one estimate transaction on the estimate channel.
// reading_ready is high only while the block is idle, so readings are handled one
// at a time. A reading with status full goes through the write and done states
// only, and its estimate is handed on once the output register is free. Any other
// reading also goes through the scan and divide states, and is done sooner when
// the leading run of samples ends early, the rate is zero or the battery is at or
// above capacity: the window scan reads one stored sample per cycle from the window
// RAM, and the shared bit-serial divider then forms, one quotient bit per cycle, the
// mean current, the hours, the minutes and the percentage. A new reading is taken
// the cycle after an estimate is handed to the output register.
// The estimate sits in an output register; when the receiver stalls, the finished
// estimate waits there while the next reading is already being worked on, and the
// block only holds once a second estimate is ready behind it.
// Reset clears the window (all samples read as zero), the write cursor and the
// remembered status, and drops estimate_valid.
module battery_runtime_estimator #(
    parameter int WINDOW_DEPTH = bre_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = bre_pkg::SAMPLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                reading_valid,
    output logic                reading_ready,
    input  bre_pkg::reading_t   reading,
    output logic                estimate_valid,
    input  logic                estimate_ready,
    output bre_pkg::estimate_t  estimate
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    // Divider width covers the widest divisor: the mean current or the full charge.
    localparam int DV_W  = (SAMPLE_BITS > bre_pkg::CHARGE_W) ? SAMPLE_BITS : bre_pkg::CHARGE_W;
    localparam int DC_W  = $clog2(DV_W + 1);
    localparam int MN_W  = DV_W + 6;
    localparam int PN_W  = bre_pkg::CHARGE_W + bre_pkg::PERCENT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_WRITE = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_MEAN  = 10'b0000001000,
        S_TIME  = 10'b0000010000,
        S_HOURS = 10'b0000100000,
        S_MINS  = 10'b0001000000,
        S_PSET  = 10'b0010000000,
        S_PCT   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [IDX_W-1:0]                    cursor_reg;
    bre_pkg::status_t                    last_status_reg;
    bre_pkg::status_t                    st_in;
    logic                                accept;
    logic                                status_change;

    logic [bre_pkg::CHARGE_W-1:0]        full_reg;
    logic [bre_pkg::CHARGE_W-1:0]        present_reg;
    logic [bre_pkg::CHARGE_W-1:0]        left_reg;
    logic [bre_pkg::CHARGE_W-1:0]        left_in;
    logic [SAMPLE_BITS-1:0]              cur_reg;
    logic                                is_full_reg;
    logic [SAMPLE_BITS-1:0]              rate_reg;
    logic                                unknown_reg;
    logic [bre_pkg::HOURS_W-1:0]         hours_reg;
    logic [bre_pkg::MINUTES_W-1:0]       mins_reg;
    logic [bre_pkg::PERCENT_W-1:0]       pct_reg;
    logic                                refresh_reg;
    logic                                estimate_valid_reg;
    bre_pkg::estimate_t                  estimate_reg;

    bre_pkg::win_cmd_t                   win_cmd;
    bre_pkg::unit_sts_t                  win_sts;
    logic [SUM_W-1:0]                    win_sum;
    logic [CNT_W-1:0]                    win_n;

    logic                                div_start;
    logic [DV_W-1:0]                     div_rem_init;
    logic [DV_W-1:0]                     div_num;
    logic [DC_W-1:0]                     div_count;
    logic [DV_W-1:0]                     div_divisor;
    bre_pkg::unit_sts_t                  div_sts;
    logic [DV_W-1:0]                     div_quot;
    logic [DV_W-1:0]                     div_rem;

    logic [MN_W-1:0]                     min_num;
    logic [PN_W-1:0]                     pct_num;
    logic                                pct_done_ge;

    // Tenths of the percentage, by multiplying with 205/2048; exact for 0..100.
    function automatic logic [bre_pkg::LEVEL_W-1:0] level_of(
        input logic [bre_pkg::PERCENT_W-1:0] pct
    );
        logic [14:0] prod;
        prod = 15'(pct) * 15'd205;
        return prod[14:11];
    endfunction

    assign reading_ready = (state_reg == S_IDLE);
    assign accept        = reading_valid && reading_ready;

    // Status decode; the unused fourth code counts as discharging.
    always_comb
    begin
        unique case (reading.charge_status)
            bre_pkg::CODE_CHARGING: st_in = bre_pkg::ST_CHARGING;
            bre_pkg::CODE_FULL:     st_in = bre_pkg::ST_FULL;
            default:                st_in = bre_pkg::ST_DISCHARGING;
        endcase
    end

    assign status_change = (st_in != last_status_reg);

    // Charge still to move: present charge when discharging, the missing charge
    // when charging, never below zero.
    always_comb
    begin
        if (st_in == bre_pkg::ST_DISCHARGING)
        begin
            left_in = reading.present_charge;
        end
        else if (reading.full_charge > reading.present_charge)
        begin
            left_in = reading.full_charge - reading.present_charge;
        end
        else
        begin
            left_in = '0;
        end
    end

    // Minutes come from the remainder of charge/rate: floor(rem*60/rate) < 60.
    assign min_num = MN_W'(div_rem) * MN_W'(bre_pkg::MINUTES_PER_HOUR);
    // The percentage divide only runs when present < full, so its quotient is below 128.
    assign pct_num = PN_W'(present_reg) * PN_W'(bre_pkg::PERCENT_FULL);
    assign pct_done_ge = (div_quot >= DV_W'(bre_pkg::PERCENT_ROUND_UP));

    bre_window #(
        .DEPTH       (WINDOW_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (win_cmd),
        .wr_addr (cursor_reg),
        .wr_data (cur_reg),
        .sts     (win_sts),
        .sum     (win_sum),
        .count   (win_n)
    );

    bre_div #(
        .WIDTH (DV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .num      (div_num),
        .count    (div_count),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Sequencer: next state, window commands and divider operands.
    always_comb
    begin
        state_next    = state_reg;
        win_cmd       = '0;
        div_start     = 1'b0;
        div_rem_init  = '0;
        div_num       = '0;
        div_count     = '0;
        div_divisor   = '0;
        win_cmd.clear = accept && status_change;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (is_full_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    win_cmd.write = 1'b1;
                    win_cmd.scan  = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (win_sts.done)
                begin
                    if (win_n == '0)
                    begin
                        state_next = S_TIME;
                    end
                    else
                    begin
                        // Mean of the run; the quotient fits in SAMPLE_BITS.
                        div_start    = 1'b1;
                        div_rem_init = DV_W'(win_sum[SUM_W-1:SAMPLE_BITS]);
                        div_num      = DV_W'(win_sum[SAMPLE_BITS-1:0]) << (DV_W - SAMPLE_BITS);
                        div_count    = DC_W'(SAMPLE_BITS);
                        div_divisor  = DV_W'(win_n);
                        state_next   = S_MEAN;
                    end
                end
            end
            S_MEAN:
            begin
                if (div_sts.done)
                begin
                    state_next = S_TIME;
                end
            end
            S_TIME:
            begin
                if (rate_reg == '0)
                begin
                    state_next = S_PSET;
                end
                else
                begin
                    div_start   = 1'b1;
                    div_num     = DV_W'(left_reg) << (DV_W - bre_pkg::CHARGE_W);
                    div_count   = DC_W'(bre_pkg::CHARGE_W);
                    div_divisor = DV_W'(rate_reg);
                    state_next  = S_HOURS;
                end
            end
            S_HOURS:
            begin
                if (div_sts.done)
                begin
                    div_start    = 1'b1;
                    div_rem_init = min_num[MN_W-1:6];
                    div_num      = DV_W'(min_num[5:0]) << (DV_W - 6);
                    div_count    = DC_W'(6);
                    div_divisor  = DV_W'(rate_reg);
                    state_next   = S_MINS;
                end
            end
            S_MINS:
            begin
                if (div_sts.done)
                begin
                    state_next = S_PSET;
                end
            end
            S_PSET:
            begin
                if ((full_reg == '0) || (present_reg >= full_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_rem_init = DV_W'(pct_num[PN_W-1:bre_pkg::PERCENT_W]);
                    div_num      = DV_W'(pct_num[bre_pkg::PERCENT_W-1:0])
                                   << (DV_W - bre_pkg::PERCENT_W);
                    div_count    = DC_W'(bre_pkg::PERCENT_W);
                    div_divisor  = DV_W'(full_reg);
                    state_next   = S_PCT;
                end
            end
            S_PCT:
            begin
                if (div_sts.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!estimate_valid_reg || estimate_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            cursor_reg         <= '0;
            last_status_reg    <= bre_pkg::ST_NONE;
            estimate_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // A new status starts a fresh window with the cursor rewound.
            if (accept && status_change)
            begin
                last_status_reg <= st_in;
                cursor_reg      <= '0;
            end
            else if (win_cmd.write)
            begin
                cursor_reg <= (cursor_reg == LAST_IDX) ? '0 : cursor_reg + 1'b1;
            end

            if ((state_reg == S_DONE) && (!estimate_valid_reg || estimate_ready))
            begin
                estimate_valid_reg <= 1'b1;
            end
            else if (estimate_ready)
            begin
                estimate_valid_reg <= 1'b0;
            end
        end
    end

    // Per-reading working registers and the estimate register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            full_reg    <= reading.full_charge;
            present_reg <= reading.present_charge;
            left_reg    <= left_in;
            cur_reg     <= SAMPLE_BITS'(reading.present_current);
            is_full_reg <= (st_in == bre_pkg::ST_FULL);
            rate_reg    <= '0;
            unknown_reg <= 1'b0;
            hours_reg   <= '0;
            mins_reg    <= '0;
            pct_reg     <= '0;
            refresh_reg <= 1'b0;
        end

        if (win_cmd.write)
        begin
            refresh_reg <= (cursor_reg == '0);
        end

        if ((state_reg == S_MEAN) && div_sts.done)
        begin
            rate_reg <= div_quot[SAMPLE_BITS-1:0];
        end

        if ((state_reg == S_TIME) && (rate_reg == '0))
        begin
            unknown_reg <= 1'b1;
        end

        if ((state_reg == S_HOURS) && div_sts.done)
        begin
            hours_reg <= div_quot[bre_pkg::HOURS_W-1:0];
        end

        if ((state_reg == S_MINS) && div_sts.done)
        begin
            mins_reg <= div_quot[bre_pkg::MINUTES_W-1:0];
        end

        if ((state_reg == S_PSET) && (full_reg != '0) && (present_reg >= full_reg))
        begin
            pct_reg <= bre_pkg::PERCENT_W'(bre_pkg::PERCENT_FULL);
        end

        if ((state_reg == S_PCT) && div_sts.done)
        begin
            pct_reg <= pct_done_ge ? bre_pkg::PERCENT_W'(bre_pkg::PERCENT_FULL)
                                   : div_quot[bre_pkg::PERCENT_W-1:0];
        end

        if ((state_reg == S_DONE) && (!estimate_valid_reg || estimate_ready))
        begin
            estimate_reg.is_full         <= is_full_reg;
            estimate_reg.time_unknown    <= unknown_reg;
            estimate_reg.hours_left      <= hours_reg;
            estimate_reg.minutes_left    <= mins_reg;
            estimate_reg.percent_charged <= pct_reg;
            estimate_reg.level_index     <= level_of(pct_reg);
            estimate_reg.refresh         <= refresh_reg;
        end
    end

    assign estimate_valid = estimate_valid_reg;
    assign estimate       = estimate_reg;

`ifndef ASSERT_OFF
    // The divider is only started when it has finished its previous job.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

    // A full battery reports nothing but the full flag.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (estimate_valid && estimate.is_full) |->
            (!estimate.time_unknown && (estimate.hours_left == '0) &&
             (estimate.minutes_left == '0) && (estimate.percent_charged == '0) &&
             (estimate.level_index == '0) && !estimate.refresh))
        else $error("full estimate carries nonzero fields");

    // An unknown rate gives no time.
    a_unknown_time: assert property (@(posedge clk) disable iff (!rst_n)
        (estimate_valid && estimate.time_unknown) |->
            ((estimate.hours_left == '0) && (estimate.minutes_left == '0)))
        else $error("unknown rate with nonzero time");

    // Minutes and percentage stay in range, and the level matches the percentage.
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        estimate_valid |->
            ((estimate.minutes_left < bre_pkg::MINUTES_W'(bre_pkg::MINUTES_PER_HOUR)) &&
             (estimate.percent_charged <= bre_pkg::PERCENT_W'(bre_pkg::PERCENT_FULL)) &&
             (estimate.level_index == level_of(estimate.percent_charged))))
        else $error("estimate field out of range");
`endif

endmodule

FILE: rtl/bre_ram.sv
module bre_ram #(
    parameter int WIDTH = bre_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH = bre_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bre_window.sv
module bre_window #(
    parameter int DEPTH       = bre_pkg::WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS = bre_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  bre_pkg::win_cmd_t                              cmd,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
    input  logic [SAMPLE_BITS-1:0]                         wr_data,
    output bre_pkg::unit_sts_t                             sts,
    output logic [SAMPLE_BITS+$clog2(DEPTH+1)-1:0]         sum,
    output logic [$clog2(DEPTH+1)-1:0]                     count
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [DEPTH-1:0]       valid_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   busy_reg;
    logic                   chk_reg;
    logic                   last_reg;
    logic                   vld_q_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   nonzero;

    bre_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (busy_reg),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // An entry that was cleared and not written since reads as zero.
    assign sample  = vld_q_reg ? rd_data : '0;
    assign nonzero = |sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            chk_reg   <= 1'b0;
            last_reg  <= 1'b0;
            vld_q_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.clear)
            begin
                valid_reg <= '0;
            end
            else if (cmd.write)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end

            if (cmd.scan)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
                chk_reg  <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                chk_reg   <= 1'b1;
                last_reg  <= (idx_reg == LAST_IDX);
                vld_q_reg <= valid_reg[idx_reg];
                if (idx_reg != LAST_IDX)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (chk_reg && nonzero)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                // The run ends at the first entry that reads as zero or at the end of the window.
                if (chk_reg && (!nonzero || last_reg))
                begin
                    busy_reg <= 1'b0;
                    chk_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            sum_reg <= '0;
        end
        else if (busy_reg && chk_reg && nonzero)
        begin
            sum_reg <= sum_reg + SUM_W'(sample);
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sum      = sum_reg;
    assign count    = cnt_reg;

endmodule

FILE: rtl/bre_div.sv
module bre_div #(
    parameter int WIDTH = bre_pkg::CHARGE_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [WIDTH-1:0]             rem_init,
    input  logic [WIDTH-1:0]             num,
    input  logic [$clog2(WIDTH+1)-1:0]   count,
    input  logic [WIDTH-1:0]             divisor,
    output bre_pkg::unit_sts_t           sts,
    output logic [WIDTH-1:0]             quot,
    output logic [WIDTH-1:0]             rem
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] num_reg;
    logic [WIDTH-1:0] quot_reg;
    logic [WIDTH-1:0] div_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             ge;

    // One quotient bit per cycle, dividend bits enter from the top of num_reg.
    // The partial remainder always stays below the divisor.
    assign shifted = {rem_reg, num_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = !diff[WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            num_reg  <= num;
            quot_reg <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            num_reg  <= {num_reg[WIDTH-2:0], 1'b0};
            quot_reg <= {quot_reg[WIDTH-2:0], ge};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = quot_reg;
    assign rem      = rem_reg;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

// Self-checking bench for the battery runtime estimator.
//
// Readings go in on a valid/ready channel and every reading gives exactly one
// estimate transaction on the output channel. The bench keeps its own copy of
// the current window, the write cursor and the remembered charge status. When
// a reading transaction is accepted, it works out the estimate that the block
// must produce, or takes the one a directed row gives, and queues it. Each estimate
// transaction is then checked field by field against the oldest queued estimate.
module tb_top;

    localparam int WINDOW_DEPTH = bre_pkg::WINDOW_DEPTH_DEF;
    localparam int SAMPLE_BITS  = bre_pkg::SAMPLE_BITS_DEF;

    // Code three is not a defined status; the block treats it as discharging.
    localparam logic [bre_pkg::STATUS_W-1:0] CODE_SPARE = 2'd3;

    localparam logic [63:0]                   SECS_PER_HOUR = 64'd3600;
    localparam logic [bre_pkg::CHARGE_W-1:0]  CHARGE_MAX    = {bre_pkg::CHARGE_W{1'b1}};
    localparam logic [bre_pkg::CURRENT_W-1:0] CURRENT_MAX   = {bre_pkg::CURRENT_W{1'b1}};

    localparam int RANDOM_READINGS = 750;
    localparam int MAX_WAIT        = 4;
    // This drain window covers anything still in flight behind the last expected
    // estimate.
    localparam int DRAIN_CYCLES    = 200;
    // The slowest legal run is about 800 readings long.
    localparam int CYCLE_LIMIT     = 500000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               reading_valid;
    logic               reading_ready;
    bre_pkg::reading_t  reading;
    logic               estimate_valid;
    logic               estimate_ready;
    bre_pkg::estimate_t estimate;

    battery_runtime_estimator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .reading_valid  (reading_valid),
        .reading_ready  (reading_ready),
        .reading        (reading),
        .estimate_valid (estimate_valid),
        .estimate_ready (estimate_ready),
        .estimate       (estimate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One row of the directed sequence. When known is set, the estimate in
    // the row is the one the block must give; otherwise the predictor decides.
    typedef struct {
        bre_pkg::reading_t  rd;
        logic               known;
        bre_pkg::estimate_t est;
    } reading_case_t;

    reading_case_t      directed_cases[$];
    bre_pkg::estimate_t pending_estimates[$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    // When set, neither side inserts idle cycles, so back-to-back traffic
    // gets exercised in stretches.
    logic               no_idle = 1'b0;

    // Predictor state, mirroring what the block keeps between readings.
    logic [SAMPLE_BITS-1:0] sample_window [WINDOW_DEPTH];
    int unsigned            sample_cursor;
    bre_pkg::status_t       held_status;

    // Works out the estimate for one reading and advances the predictor state.
    function automatic bre_pkg::estimate_t estimate_runtime(bre_pkg::reading_t rd);
        bre_pkg::status_t   st;
        logic [63:0]        sum;
        logic [63:0]        count;
        logic [63:0]        rate;
        logic [63:0]        left;
        logic [63:0]        secs;
        logic [63:0]        hours;
        logic [63:0]        minutes;
        logic [63:0]        pct;
        logic               run_open;
        bre_pkg::estimate_t est;

        if (rd.charge_status == bre_pkg::CODE_CHARGING)
            st = bre_pkg::ST_CHARGING;
        else if (rd.charge_status == bre_pkg::CODE_FULL)
            st = bre_pkg::ST_FULL;
        else
            st = bre_pkg::ST_DISCHARGING;

        if (sample_cursor >= WINDOW_DEPTH)
            sample_cursor = 0;

        // Any status change throws away the collected samples.
        if (st != held_status)
        begin
            sample_cursor = 0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                sample_window[i] = '0;
            held_status = st;
        end

        est = '0;
        if (st == bre_pkg::ST_FULL)
        begin
            est.is_full = 1'b1;
            return est;
        end

        sample_window[sample_cursor] = rd.present_current[SAMPLE_BITS-1:0];

        // The rate is the mean over the leading run of nonzero samples.
        sum      = '0;
        count    = '0;
        run_open = 1'b1;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (sample_window[i] == '0)
                run_open = 1'b0;
            if (run_open)
            begin
                sum   = sum + 64'(sample_window[i]);
                count = count + 64'd1;
            end
        end
        rate = (count != 0) ? sum / count : 64'd0;

        if (st == bre_pkg::ST_DISCHARGING)
            left = 64'(rd.present_charge);
        else if (rd.full_charge > rd.present_charge)
            left = 64'(rd.full_charge - rd.present_charge);
        else
            left = 64'd0;

        if (rate == 0)
        begin
            est.time_unknown = 1'b1;
        end
        else
        begin
            secs             = (left * SECS_PER_HOUR) / rate;
            hours            = secs / SECS_PER_HOUR;
            minutes          = (secs % SECS_PER_HOUR) / 64'(bre_pkg::MINUTES_PER_HOUR);
            est.hours_left   = hours[bre_pkg::HOURS_W-1:0];
            est.minutes_left = minutes[bre_pkg::MINUTES_W-1:0];
        end

        pct = 64'd0;
        if (rd.full_charge != 0)
        begin
            pct = (64'(rd.present_charge) * 64'(bre_pkg::PERCENT_FULL))
                  / 64'(rd.full_charge);
            if (pct >= 64'(bre_pkg::PERCENT_ROUND_UP))
                pct = 64'(bre_pkg::PERCENT_FULL);
        end
        est.percent_charged = pct[bre_pkg::PERCENT_W-1:0];
        est.level_index     = bre_pkg::LEVEL_W'(pct / 64'd10);
        est.refresh         = (sample_cursor == 0);

        sample_cursor = (sample_cursor + 1) % WINDOW_DEPTH;
        return est;
    endfunction

    function automatic bre_pkg::reading_t make_reading(
        logic [bre_pkg::CHARGE_W-1:0]  full,
        logic [bre_pkg::CHARGE_W-1:0]  present,
        logic [bre_pkg::CURRENT_W-1:0] current,
        logic [bre_pkg::STATUS_W-1:0]  code
    );
        bre_pkg::reading_t rd;
        rd.full_charge     = full;
        rd.present_charge  = present;
        rd.present_current = current;
        rd.charge_status   = code;
        return rd;
    endfunction

    function automatic bre_pkg::estimate_t make_estimate(
        logic                          full,
        logic                          unknown,
        logic [bre_pkg::HOURS_W-1:0]   hours,
        logic [bre_pkg::MINUTES_W-1:0] minutes,
        logic [bre_pkg::PERCENT_W-1:0] pct,
        logic [bre_pkg::LEVEL_W-1:0]   level,
        logic                          refresh
    );
        bre_pkg::estimate_t est;
        est.is_full         = full;
        est.time_unknown    = unknown;
        est.hours_left      = hours;
        est.minutes_left    = minutes;
        est.percent_charged = pct;
        est.level_index     = level;
        est.refresh         = refresh;
        return est;
    endfunction

    function automatic void add_case(bre_pkg::reading_t rd, logic known,
                                     bre_pkg::estimate_t est);
        reading_case_t c;
        c.rd    = rd;
        c.known = known;
        c.est   = est;
        directed_cases.push_back(c);
    endfunction

    // Presents one reading after an optional idle gap and returns at the
    // clock edge where the transaction is accepted. With a zero gap the
    // valid stays high and only the payload changes.
    task automatic send_reading(bre_pkg::reading_t rd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            reading_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        reading_valid <= 1'b1;
        reading       <= rd;
        @(posedge clk);
        while (!reading_ready)
            @(posedge clk);
    endtask

    // Random reading in the given status code. Most capacities are ordinary,
    // with zero and the maximum mixed in, and the present charge sometimes
    // sits above capacity. Currents span small, mid and full range values,
    // with zeros to cut the leading run of the window short.
    function automatic bre_pkg::reading_t random_reading(
        logic [bre_pkg::STATUS_W-1:0] code
    );
        logic [bre_pkg::CHARGE_W-1:0]  full;
        logic [bre_pkg::CHARGE_W-1:0]  present;
        logic [bre_pkg::CURRENT_W-1:0] current;
        int                            pick;

        pick = $urandom_range(0, 9);
        if (pick == 0)
            full = '0;
        else if (pick == 1)
            full = CHARGE_MAX;
        else
            full = bre_pkg::CHARGE_W'($urandom_range(1, 32'(CHARGE_MAX)));

        pick = $urandom_range(0, 19);
        if (pick < 3)
            present = bre_pkg::CHARGE_W'($urandom_range(32'(full), 32'(CHARGE_MAX)));
        else if (pick == 3)
            present = CHARGE_MAX;
        else if (pick == 4)
            present = '0;
        else
            present = bre_pkg::CHARGE_W'($urandom_range(0, 32'(full)));

        pick = $urandom_range(0, 9);
        if (pick == 0)
            current = '0;
        else if (pick < 4)
            current = bre_pkg::CURRENT_W'($urandom_range(1, 255));
        else if (pick < 7)
            current = bre_pkg::CURRENT_W'($urandom());
        else
            current = bre_pkg::CURRENT_W'($urandom_range(1000, 3000000));

        return make_reading(full, present, current, code);
    endfunction

    // Reset, then the directed rows, then random runs of readings.
    initial
    begin
        logic [bre_pkg::STATUS_W-1:0] run_code;
        int                           run_left;
        int                           pick;
        bre_pkg::reading_t            rd;
        bre_pkg::estimate_t           predicted;

        rst_n          <= 1'b0;
        reading_valid  <= 1'b0;
        reading        <= '0;
        sample_cursor   = 0;
        held_status     = bre_pkg::ST_NONE;
        for (int i = 0; i < WINDOW_DEPTH; i++)
            sample_window[i] = '0;

        // Full right after reset, at both ends of the field ranges.
        add_case(make_reading('0, '0, '0, bre_pkg::CODE_FULL), 1'b1,
                 make_estimate(1'b1, 1'b0, '0, '0, '0, '0, 1'b0));
        add_case(make_reading(CHARGE_MAX, CHARGE_MAX, CURRENT_MAX, bre_pkg::CODE_FULL),
                 1'b1, make_estimate(1'b1, 1'b0, '0, '0, '0, '0, 1'b0));
        // Zero capacity and a zero sample: rate unknown, window just cleared.
        add_case(make_reading('0, '0, '0, bre_pkg::CODE_DISCHARGING), 1'b1,
                 make_estimate(1'b0, 1'b1, '0, '0, '0, '0, 1'b1));
        // The first slot is still zero, so the leading run is empty.
        add_case(make_reading(24'd1000, 24'd1000, 24'd1000, bre_pkg::CODE_DISCHARGING),
                 1'b1, make_estimate(1'b0, 1'b1, '0, '0, 7'd100, 4'd10, 1'b0));
        // Charging from empty at full current: exactly one hour.
        add_case(make_reading(CHARGE_MAX, '0, CURRENT_MAX, bre_pkg::CODE_CHARGING), 1'b1,
                 make_estimate(1'b0, 1'b0, 24'd1, '0, '0, '0, 1'b1));
        // Charging with present above capacity: nothing left, reports 100.
        add_case(make_reading(24'd100, 24'd200, 24'd50, bre_pkg::CODE_CHARGING), 1'b1,
                 make_estimate(1'b0, 1'b0, '0, '0, 7'd100, 4'd10, 1'b0));
        add_case(make_reading(24'd1000, 24'd400, '0, bre_pkg::CODE_CHARGING), 1'b0, '0);
        // Largest charge over the smallest current gives the largest hours.
        add_case(make_reading(CHARGE_MAX, CHARGE_MAX, 24'd1, bre_pkg::CODE_DISCHARGING),
                 1'b1, make_estimate(1'b0, 1'b0, CHARGE_MAX, '0, 7'd100, 4'd10, 1'b1));
        // Code three keeps the discharging window going.
        add_case(make_reading(24'd3000000, 24'd1500000, 24'd500000, CODE_SPARE),
                 1'b0, '0);
        // Enough discharging readings to wrap the cursor, with the percentage
        // just at and just under the round-up point.
        add_case(make_reading(24'd2000000, 24'd1980000, 24'd123456,
                              bre_pkg::CODE_DISCHARGING), 1'b0, '0);
        add_case(make_reading(24'd2000000, 24'd1979999, 24'd654321,
                              bre_pkg::CODE_DISCHARGING), 1'b0, '0);
        add_case(make_reading(24'd4000000, 24'd1234567, 24'd77,
                              bre_pkg::CODE_DISCHARGING), 1'b0, '0);
        add_case(make_reading(24'd4000000, 24'd900000, 24'd350000, CODE_SPARE),
                 1'b0, '0);
        add_case(make_reading(24'd500000, 24'd12345, 24'd999,
                              bre_pkg::CODE_DISCHARGING), 1'b0, '0);
        add_case(make_reading(24'd8000000, 24'd7000000, CURRENT_MAX,
                              bre_pkg::CODE_DISCHARGING), 1'b0, '0);
        add_case(make_reading(24'd8000000, 24'd10, 24'd3,
                              bre_pkg::CODE_DISCHARGING), 1'b0, '0);
        add_case(make_reading(24'd1, '0, 24'd1000000, bre_pkg::CODE_DISCHARGING),
                 1'b0, '0);
        add_case(make_reading(24'd2500, 24'd2499, 24'd42, bre_pkg::CODE_DISCHARGING),
                 1'b0, '0);
        add_case(make_reading(24'd5000000, 24'd2500000, 24'd1500,
                              bre_pkg::CODE_DISCHARGING), 1'b0, '0);
        add_case(make_reading(24'd5000000, 24'd2500000, '0, bre_pkg::CODE_DISCHARGING),
                 1'b0, '0);
        // Zero capacity while charging: the percentage is zero and no time is left.
        add_case(make_reading('0, 24'd5000, 24'd700, bre_pkg::CODE_CHARGING), 1'b1,
                 make_estimate(1'b0, 1'b0, '0, '0, '0, '0, 1'b1));
        add_case(make_reading('0, '0, '0, bre_pkg::CODE_FULL), 1'b1,
                 make_estimate(1'b1, 1'b0, '0, '0, '0, '0, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
        begin
            send_reading(directed_cases[i].rd);
            predicted = estimate_runtime(directed_cases[i].rd);
            pending_estimates.push_back(directed_cases[i].known ?
                                        directed_cases[i].est : predicted);
        end

        // Random part: runs of readings in one status so the window fills and
        // wraps, with full readings and status changes breaking the runs.
        run_left = 0;
        run_code = bre_pkg::CODE_CHARGING;
        for (int k = 0; k < RANDOM_READINGS; k++)
        begin
            if (k % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 24);
                pick     = $urandom_range(0, 9);
                if (pick < 4)
                    run_code = bre_pkg::CODE_CHARGING;
                else if (pick < 8)
                    run_code = bre_pkg::CODE_DISCHARGING;
                else
                    run_code = bre_pkg::CODE_FULL;
            end
            run_left = run_left - 1;

            if (run_code == bre_pkg::CODE_DISCHARGING && $urandom_range(0, 7) == 0)
                rd = random_reading(CODE_SPARE);
            else
                rd = random_reading(run_code);

            send_reading(rd);
            pending_estimates.push_back(estimate_runtime(rd));
        end
        reading_valid <= 1'b0;

        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_estimates.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Output side: stalls at random, then takes one estimate transaction and
    // checks it against the oldest pending estimate.
    initial
    begin
        int                 stall;
        bre_pkg::estimate_t want;

        estimate_ready <= 1'b0;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                estimate_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            estimate_ready <= 1'b1;
            @(posedge clk);
            while (!estimate_valid)
                @(posedge clk);

            if (pending_estimates.size() == 0)
            begin
                $error("estimate transaction arrived with no reading pending");
                error_count++;
            end
            else
            begin
                want = pending_estimates.pop_front();
                if (estimate.is_full !== want.is_full)
                begin
                    $error("is_full: expected %0d, got %0d", want.is_full, estimate.is_full);
                    error_count++;
                end
                if (estimate.time_unknown !== want.time_unknown)
                begin
                    $error("time_unknown: expected %0d, got %0d",
                           want.time_unknown, estimate.time_unknown);
                    error_count++;
                end
                if (estimate.hours_left !== want.hours_left)
                begin
                    $error("hours_left: expected %0d, got %0d",
                           want.hours_left, estimate.hours_left);
                    error_count++;
                end
                if (estimate.minutes_left !== want.minutes_left)
                begin
                    $error("minutes_left: expected %0d, got %0d",
                           want.minutes_left, estimate.minutes_left);
                    error_count++;
                end
                if (estimate.percent_charged !== want.percent_charged)
                begin
                    $error("percent_charged: expected %0d, got %0d",
                           want.percent_charged, estimate.percent_charged);
                    error_count++;
                end
                if (estimate.level_index !== want.level_index)
                begin
                    $error("level_index: expected %0d, got %0d",
                           want.level_index, estimate.level_index);
                    error_count++;
                end
                if (estimate.refresh !== want.refresh)
                begin
                    $error("refresh: expected %0d, got %0d", want.refresh, estimate.refresh);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
